@@ rtl/sctb_pkg.sv @@
package sctb_pkg;

    localparam int SLOT_BYTES_DEF = 1024;
    localparam int SLOT_COUNT_DEF = 32;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 11;
    localparam int ST_W    = 3;
    localparam int PEND_W  = 16;
    localparam int SLOT_W  = 5;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = ST_W;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_DONE   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BADLEN  = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [ST_W-1:0] ST_IGNORED = 3'd4;

    typedef logic [3:0] act_t;

    localparam act_t ACT_NONE      = 4'd0;
    localparam act_t ACT_LOAD      = 4'd1;
    localparam act_t ACT_BADLEN    = 4'd2;
    localparam act_t ACT_FULL      = 4'd3;
    localparam act_t ACT_APPEND    = 4'd4;
    localparam act_t ACT_EMPTY     = 4'd5;
    localparam act_t ACT_DRAIN_RD  = 4'd6;
    localparam act_t ACT_DRAIN_OUT = 4'd7;
    localparam act_t ACT_DONE      = 4'd8;
    localparam act_t ACT_CLEAR     = 4'd9;

    typedef struct packed {
        logic sel_next;
        act_t act;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            first;
        logic            len_bad;
        logic            fits_cur;
        logic            slot_used;
        logic            nothing;
        logic            out_busy;
    } stat_t;

endpackage

@@ rtl/sctb_ctrl.sv @@
module sctb_ctrl
    import sctb_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_RDN  = 3'd3;
    localparam logic [2:0] S_NXT  = 3'd4;
    localparam logic [2:0] S_DRD  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE) && aresetn;

    always_comb begin
        state_next   = state_reg;
        cmd.sel_next = (state_reg == S_RDN) || (state_reg == S_NXT);
        cmd.act      = ACT_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.act    = ACT_LOAD;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (!stat.out_busy) begin
                    state_next = S_IDLE;
                    case (stat.op)
                        OP_APPEND: begin
                            if (stat.first && stat.len_bad) begin
                                cmd.act = ACT_BADLEN;
                            end else if (stat.first && !stat.fits_cur) begin
                                state_next = S_RDN;
                            end else begin
                                cmd.act = ACT_APPEND;
                            end
                        end
                        OP_DRAIN: begin
                            if (stat.nothing) begin
                                cmd.act = ACT_EMPTY;
                            end else begin
                                cmd.act    = ACT_DRAIN_RD;
                                state_next = S_DRD;
                            end
                        end
                        OP_DONE: begin
                            cmd.act = stat.nothing ? ACT_EMPTY : ACT_DONE;
                        end
                        default: begin
                            cmd.act = ACT_CLEAR;
                        end
                    endcase
                end
            end
            S_RDN: begin
                state_next = S_NXT;
            end
            S_NXT: begin
                cmd.act    = stat.slot_used ? ACT_FULL : ACT_APPEND;
                state_next = S_IDLE;
            end
            S_DRD: begin
                cmd.act    = ACT_DRAIN_OUT;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/sctb_dpath.sv @@
module sctb_dpath
    import sctb_pkg::*;
#(
    parameter int SLOT_BYTES = SLOT_BYTES_DEF,
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tready,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam int IW     = $clog2(SLOT_COUNT);
    localparam int OW     = $clog2(SLOT_BYTES);
    localparam int FW     = $clog2(SLOT_BYTES + 1);
    localparam int AW     = IW + OW;
    localparam int BDEPTH = SLOT_COUNT << OW;
    localparam int CW     = ((FW > LEN_W) ? FW : LEN_W) + 1;

    logic [OP_W-1:0]   in_op_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [LEN_W-1:0]  in_len_reg;
    logic              in_first_reg;
    logic              in_ok_reg;

    logic [IW-1:0]     fill_idx_reg, fill_idx_next;
    logic [IW-1:0]     drain_idx_reg, drain_idx_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [OW-1:0]     off_reg, off_next;
    logic              acc_reg, acc_next;
    logic [FW-1:0]     left_reg, left_next;
    logic [SLOT_COUNT-1:0] valid_reg;

    logic [BYTE_W-1:0] bmem [BDEPTH];
    logic [FW-1:0]     fmem [SLOT_COUNT];

    logic [FW-1:0]     fa_q, fb_q;
    logic              fva_q, fvb_q;
    logic [FW-1:0]     fa, fb;
    logic [BYTE_W-1:0] byte_q;
    logic              dlast_reg;

    logic [IW-1:0]     nxt_idx;
    logic [IW-1:0]     tgt_idx;
    logic [CW-1:0]     sum_cur;
    logic              acc_e;
    logic [FW-1:0]     left_e;
    logic              store_ok;
    logic [OW-1:0]     off_e;
    logic [FW-1:0]     off_p1;
    logic              dlast;
    logic [PEND_W-1:0] pend_inc;
    logic              fw_en;
    logic              free_en;
    logic              fin;
    logic [ST_W-1:0]   st;
    logic [BYTE_W-1:0] obyte;
    logic              olast;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic                 m_tlast_reg;

    assign nxt_idx = (fill_idx_reg == IW'(SLOT_COUNT - 1)) ? '0 : fill_idx_reg + 1'b1;
    assign tgt_idx = cmd.sel_next ? nxt_idx : fill_idx_reg;

    assign fa = fva_q ? fa_q : '0;
    assign fb = fvb_q ? fb_q : '0;

    assign sum_cur  = CW'(fa) + CW'(in_len_reg);
    assign acc_e    = in_first_reg ? 1'b1 : acc_reg;
    assign left_e   = in_first_reg ? FW'(in_len_reg) : left_reg;
    assign store_ok = acc_e && (left_e != '0) && (fa < FW'(SLOT_BYTES));

    assign off_e    = (FW'(off_reg) >= fb) ? '0 : off_reg;
    assign off_p1   = FW'(off_e) + 1'b1;
    assign dlast    = (off_p1 >= fb);
    assign pend_inc = (pend_reg == '1) ? pend_reg : pend_reg + 1'b1;

    assign stat.op        = in_op_reg;
    assign stat.first     = in_first_reg;
    assign stat.len_bad   = (in_len_reg == '0) || (CW'(in_len_reg) > CW'(SLOT_BYTES));
    assign stat.fits_cur  = (sum_cur <= CW'(SLOT_BYTES));
    assign stat.slot_used = (fa != '0);
    assign stat.nothing   = (pend_reg == '0) || (fb == '0);
    assign stat.out_busy  = m_tvalid_reg && !m_tready;

    always_comb begin
        fill_idx_next  = fill_idx_reg;
        drain_idx_next = drain_idx_reg;
        pend_next      = pend_reg;
        off_next       = off_reg;
        acc_next       = acc_reg;
        left_next      = left_reg;
        fw_en          = 1'b0;
        free_en        = 1'b0;
        fin            = 1'b1;
        st             = ST_OK;
        obyte          = '0;
        olast          = 1'b0;
        case (cmd.act)
            ACT_BADLEN: begin
                acc_next  = 1'b0;
                left_next = '0;
                st        = ST_BADLEN;
            end
            ACT_FULL: begin
                acc_next  = 1'b0;
                left_next = '0;
                st        = ST_FULL;
            end
            ACT_APPEND: begin
                if (cmd.sel_next) begin
                    fill_idx_next = nxt_idx;
                end
                if (store_ok) begin
                    fw_en     = 1'b1;
                    left_next = left_e - 1'b1;
                    acc_next  = (left_e != FW'(1));
                    pend_next = pend_inc;
                end else begin
                    acc_next  = acc_e;
                    left_next = left_e;
                    st        = ST_IGNORED;
                end
            end
            ACT_EMPTY: begin
                st = ST_EMPTY;
            end
            ACT_DRAIN_RD: begin
                fin      = 1'b0;
                off_next = dlast ? '0 : off_p1[OW-1:0];
            end
            ACT_DRAIN_OUT: begin
                obyte = byte_q;
                olast = dlast_reg;
            end
            ACT_DONE: begin
                off_next = '0;
                if (in_ok_reg) begin
                    free_en   = 1'b1;
                    pend_next = (pend_reg >= PEND_W'(fb)) ? pend_reg - PEND_W'(fb) : '0;
                    if (drain_idx_reg != fill_idx_reg) begin
                        drain_idx_next = (drain_idx_reg == IW'(SLOT_COUNT - 1)) ?
                                         '0 : drain_idx_reg + 1'b1;
                    end
                end
            end
            ACT_CLEAR: begin
                fill_idx_next  = '0;
                drain_idx_next = '0;
                pend_next      = '0;
                off_next       = '0;
                acc_next       = 1'b0;
                left_next      = '0;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.act == ACT_LOAD) begin
            in_op_reg    <= s_tuser[OP_W-1:0];
            in_first_reg <= s_tuser[OP_W];
            in_byte_reg  <= s_tdata[BYTE_W-1:0];
            in_len_reg   <= s_tdata[BYTE_W +: LEN_W];
            in_ok_reg    <= s_tdata[BYTE_W + LEN_W];
        end
    end

    always_ff @(posedge aclk) begin
        fa_q  <= fmem[tgt_idx];
        fva_q <= valid_reg[tgt_idx];
        fb_q  <= fmem[drain_idx_reg];
        fvb_q <= valid_reg[drain_idx_reg];
        if (fw_en) begin
            fmem[tgt_idx] <= fa + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fw_en) begin
            bmem[AW'({tgt_idx, fa[OW-1:0]})] <= in_byte_reg;
        end
        if (cmd.act == ACT_DRAIN_RD) begin
            byte_q    <= bmem[AW'({drain_idx_reg, off_e})];
            dlast_reg <= dlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_idx_reg  <= '0;
            drain_idx_reg <= '0;
            pend_reg      <= '0;
            off_reg       <= '0;
            acc_reg       <= 1'b0;
            left_reg      <= '0;
            valid_reg     <= '0;
        end else begin
            fill_idx_reg  <= fill_idx_next;
            drain_idx_reg <= drain_idx_next;
            pend_reg      <= pend_next;
            off_reg       <= off_next;
            acc_reg       <= acc_next;
            left_reg      <= left_next;
            if (cmd.act == ACT_CLEAR) begin
                valid_reg <= '0;
            end else if (fw_en) begin
                valid_reg[tgt_idx] <= 1'b1;
            end else if (free_en) begin
                valid_reg[drain_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fin) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin) begin
            m_tdata_reg <= {6'd0, SLOT_W'(drain_idx_next), SLOT_W'(fill_idx_next),
                            pend_next, obyte};
            m_tuser_reg <= st;
            m_tlast_reg <= olast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ rtl/slot_coalescing_tx_buffer.sv @@
// Transmit buffer that packs whole messages into a ring of SLOT_COUNT slots of
// SLOT_BYTES bytes, one slot per outgoing segment. Each input transaction
// (append, drain, segment done, clear) returns exactly one result transaction.
// Items are handled one at a time. An item passes through accept, slot-fill
// read and execute states. A drain adds a registered byte-memory read state,
// and a first byte that opens the next slot adds states that read that slot's
// fill count. A result register lets the next item be accepted while a result
// is still waiting on m_tready; that item then holds in its execute state until
// the register frees. Slot fill counts carry per-slot valid bits, so reset and
// clear take effect at once with no clearing pass.
module slot_coalescing_tx_buffer
    import sctb_pkg::*;
#(
    parameter int SLOT_BYTES = SLOT_BYTES_DEF,
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // data_byte[7:0], message_length[18:8], send_ok[19], zero[23:20]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation[1:0], first_byte[2]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_byte[7:0], pending_bytes[23:8], write_slot[28:24], read_slot[33:29],
    // zero[39:34]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    sctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sctb_dpath #(
        .SLOT_BYTES (SLOT_BYTES),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/sctb_checker.sv @@
module sctb_checker
    import sctb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ST_IGNORED))
        else $error("undefined status code");

    a_last_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == ST_OK))
        else $error("segment end flagged on a failed transaction");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[7:0] == 8'd0 && !m_tlast))
        else $error("byte data on a failed transaction");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

bind slot_coalescing_tx_buffer sctb_checker u_sctb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/sv/tb_slot_coalescing_tx_buffer.sv @@
`timescale 1ns / 1ps

import sctb_pkg::*;

typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [PEND_W-1:0] pending;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
} tx_result_t;

class tx_slot_tracker;
    logic [BYTE_W-1:0] slot_mem [SLOT_COUNT_DEF*SLOT_BYTES_DEF];
    int unsigned slot_fill [SLOT_COUNT_DEF];
    int unsigned wr_idx;
    int unsigned rd_idx;
    int unsigned pend_total;
    int unsigned drain_ofs;
    int unsigned msg_left;
    bit          msg_open;

    tx_result_t  expected_results [$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned useful_items;
    int unsigned segment_ends;
    int unsigned peak_pending;
    int unsigned status_hits [5];

    function new();
        empty_ring();
        mismatches = 0;
        results_checked = 0;
        useful_items = 0;
        segment_ends = 0;
        peak_pending = 0;
        foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void empty_ring();
        foreach (slot_fill[i]) slot_fill[i] = 0;
        wr_idx = 0;
        rd_idx = 0;
        pend_total = 0;
        drain_ofs = 0;
        msg_left = 0;
        msg_open = 1'b0;
    endfunction

    function void note_transaction(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                   logic [LEN_W-1:0] len, logic first, logic ok);
        tx_result_t  r;
        int unsigned head_fill;
        int unsigned nxt;
        r = '0;
        head_fill = slot_fill[rd_idx];
        case (op)
            OP_APPEND: begin
                if (first) begin
                    msg_open = 1'b0;
                    msg_left = 0;
                    nxt = (wr_idx + 1) % SLOT_COUNT_DEF;
                    if (len == 0 || len > SLOT_BYTES_DEF) begin
                        r.status = ST_BADLEN;
                    end else if (slot_fill[wr_idx] + len > SLOT_BYTES_DEF &&
                                 slot_fill[nxt] > 0) begin
                        r.status = ST_FULL;
                    end else begin
                        if (slot_fill[wr_idx] + len > SLOT_BYTES_DEF) wr_idx = nxt;
                        msg_open = 1'b1;
                        msg_left = len;
                    end
                end
                if (r.status == ST_OK) begin
                    if (!msg_open || msg_left == 0 || slot_fill[wr_idx] >= SLOT_BYTES_DEF) begin
                        r.status = ST_IGNORED;
                    end else begin
                        slot_mem[wr_idx*SLOT_BYTES_DEF + slot_fill[wr_idx]] = data;
                        slot_fill[wr_idx]++;
                        msg_left--;
                        if (msg_left == 0) msg_open = 1'b0;
                        if (pend_total < 32'hFFFF) pend_total++;
                    end
                end
            end
            OP_DRAIN: begin
                if (pend_total == 0 || head_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (drain_ofs >= head_fill) drain_ofs = 0;
                    r.out_byte = slot_mem[rd_idx*SLOT_BYTES_DEF + drain_ofs];
                    drain_ofs++;
                    if (drain_ofs >= head_fill) begin
                        r.last = 1'b1;
                        drain_ofs = 0;
                    end
                end
            end
            OP_DONE: begin
                if (pend_total == 0 || head_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (ok) begin
                        slot_fill[rd_idx] = 0;
                        pend_total = (pend_total >= head_fill) ? pend_total - head_fill : 0;
                        if (rd_idx != wr_idx) rd_idx = (rd_idx + 1) % SLOT_COUNT_DEF;
                    end
                    drain_ofs = 0;
                end
            end
            default: begin
                empty_ring();
            end
        endcase
        r.pending = PEND_W'(pend_total);
        r.wr_slot = SLOT_W'(wr_idx);
        r.rd_slot = SLOT_W'(rd_idx);
        expected_results.push_back(r);
        if (r.status != ST_IGNORED) useful_items++;
        status_hits[r.status]++;
        segment_ends += r.last;
        if (pend_total > peak_pending) peak_pending = pend_total;
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser,
                               logic tlast);
        tx_result_t        e;
        logic [PEND_W-1:0] want [6];
        logic [PEND_W-1:0] got [6];
        string             tag [6];
        if (expected_results.size() == 0) begin
            if (mismatches < 10)
                $display("result with nothing expected: tdata=%h tuser=%h tlast=%b",
                         tdata, tuser, tlast);
            mismatches++;
            return;
        end
        e = expected_results.pop_front();
        results_checked++;
        tag = '{"status", "out_byte", "segment_last", "pending_bytes", "write_slot",
                "read_slot"};
        want[0] = PEND_W'(e.status);
        want[1] = PEND_W'(e.out_byte);
        want[2] = PEND_W'(e.last);
        want[3] = e.pending;
        want[4] = PEND_W'(e.wr_slot);
        want[5] = PEND_W'(e.rd_slot);
        got[0] = PEND_W'(tuser);
        got[1] = PEND_W'(tdata[7:0]);
        got[2] = PEND_W'(tlast);
        got[3] = tdata[23:8];
        got[4] = PEND_W'(tdata[28:24]);
        got[5] = PEND_W'(tdata[33:29]);
        for (int i = 0; i < 6; i++) begin
            if (got[i] !== want[i]) begin
                if (mismatches < 10)
                    $display("result %0d: %s expected %0d, got %0d",
                             results_checked, tag[i], want[i], got[i]);
                mismatches++;
            end
        end
    endfunction
endclass

module tb_slot_coalescing_tx_buffer;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    tx_slot_tracker tracker;
    int unsigned    stall_req;
    bit             tx_burst;
    int unsigned    items_sent;

    slot_coalescing_tx_buffer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                             input logic [LEN_W-1:0] len, input logic first,
                             input logic ok);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, ok, len, data};
        s_tuser  <= {first, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_transaction(op, data, len, first, ok);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (tracker.expected_results.size() != 0);
    endtask

    initial begin : result_sink
        int unsigned pause_len;
        bit          rx_calm;
        rx_calm = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_req != 0) begin
                m_tready <= 1'b0;
                repeat (stall_req) @(negedge aclk);
                stall_req = 0;
            end
            if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            pause_len = rx_calm ? 0 : $urandom_range(0, 12);
            if (pause_len != 0) begin
                m_tready <= 1'b0;
                repeat (pause_len) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            tracker.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", tracker.expected_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned len;
        int unsigned nbytes;
        int unsigned pick;
        bit          paused;
        tracker    = new();
        stall_req  = 0;
        tx_burst   = 1'b0;
        items_sent = 0;
        paused     = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(OP_DRAIN,  8'h00, 11'd0,    1'b0, 1'b0);
        send_item(OP_DONE,   8'h00, 11'd0,    1'b0, 1'b1);
        send_item(OP_APPEND, 8'h11, 11'd5,    1'b0, 1'b0);
        send_item(OP_APPEND, 8'hFF, 11'd0,    1'b1, 1'b0);
        send_item(OP_APPEND, 8'h22, 11'd0,    1'b0, 1'b0);
        send_item(OP_APPEND, 8'h33, 11'd1025, 1'b1, 1'b0);
        send_item(OP_APPEND, 8'h44, 11'd2047, 1'b1, 1'b1);
        send_item(OP_APPEND, 8'h00, 11'd3,    1'b1, 1'b0);
        send_item(OP_APPEND, 8'hFF, 11'd0,    1'b0, 1'b0);
        send_item(OP_APPEND, 8'hA5, 11'd0,    1'b0, 1'b0);
        send_item(OP_APPEND, 8'h66, 11'd0,    1'b0, 1'b0);
        // fits exactly: joins slot 0, then abandoned by the next first byte
        send_item(OP_APPEND, 8'h5A, 11'd1021, 1'b1, 1'b0);
        send_item(OP_APPEND, 8'hC3, 11'd1021, 1'b1, 1'b0);
        send_item(OP_DRAIN,  8'h00, 11'd0,    1'b0, 1'b0);
        send_item(OP_DRAIN,  8'h00, 11'd0,    1'b0, 1'b0);
        send_item(OP_DRAIN,  8'h00, 11'd0,    1'b0, 1'b0);
        send_item(OP_DRAIN,  8'h00, 11'd0,    1'b0, 1'b0);
        send_item(OP_DRAIN,  8'h00, 11'd0,    1'b0, 1'b0);
        send_item(OP_DONE,   8'h00, 11'd0,    1'b0, 1'b0);
        send_item(OP_DRAIN,  8'h00, 11'd0,    1'b0, 1'b0);
        send_item(OP_DONE,   8'h00, 11'd0,    1'b0, 1'b1);
        send_item(OP_DONE,   8'h00, 11'd0,    1'b0, 1'b1);
        send_item(OP_DRAIN,  8'h00, 11'd0,    1'b0, 1'b0);
        send_item(OP_APPEND, 8'h3C, 11'd2,    1'b1, 1'b0);
        send_item(OP_CLEAR,  8'hFF, 11'd2047, 1'b1, 1'b1);

        // hold the result side while a long message streams in back to back
        stall_req = 300;
        tx_burst  = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(OP_APPEND, 8'($urandom), (i == 0) ? 11'd40 : 11'($urandom),
                      i == 0, 1'($urandom));
        tx_burst = 1'b0;

        while (items_sent < 700) begin
            if (!paused && items_sent >= 350) begin
                wait_results_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) tx_burst = !tx_burst;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(900, SLOT_BYTES_DEF)
                                                  : $urandom_range(1, 16);
                nbytes = (len > 16) ? $urandom_range(1, 6) : len;
                case ($urandom_range(0, 7))
                    0: nbytes += $urandom_range(1, 2);
                    1: if (nbytes > 1) nbytes--;
                    default: ;
                endcase
                for (int i = 0; i < nbytes; i++)
                    send_item(OP_APPEND, 8'($urandom), (i == 0) ? LEN_W'(len) : 11'($urandom),
                              i == 0, 1'($urandom));
            end else if (pick < 65) begin
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++)
                    send_item(OP_DRAIN, 8'($urandom), 11'($urandom), 1'($urandom),
                              1'($urandom));
                send_item(OP_DONE, 8'($urandom), 11'($urandom), 1'($urandom),
                          $urandom_range(0, 3) != 0);
            end else if (pick < 72) begin
                send_item(OP_DONE, 8'($urandom), 11'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick < 80) begin
                // walk the write index around the ring with near-full messages
                n = $urandom_range(8, 34);
                for (int i = 0; i < n; i++)
                    send_item(OP_APPEND, 8'($urandom),
                              LEN_W'($urandom_range(1020, SLOT_BYTES_DEF)), 1'b1, 1'b0);
            end else if (pick < 97) begin
                send_item(OP_W'($urandom_range(0, 2)), 8'($urandom),
                          LEN_W'($urandom_range(0, 2047)), 1'($urandom), 1'($urandom));
            end else begin
                send_item(OP_CLEAR, 8'($urandom), 11'($urandom), 1'($urandom), 1'($urandom));
            end
        end

        wait_results_drained();
        repeat (16) @(posedge aclk);

        $display("%0d transactions sent (%0d not ignored), %0d results checked, %0d mismatches",
                 items_sent, tracker.useful_items, tracker.results_checked,
                 tracker.mismatches);
        $display("%0d segment ends; status mix: ok %0d, bad length %0d, ring full %0d, empty %0d, ignored %0d",
                 tracker.segment_ends, tracker.status_hits[0], tracker.status_hits[1],
                 tracker.status_hits[2], tracker.status_hits[3], tracker.status_hits[4]);
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
